@@ rtl/core/facrr_pkg.sv @@
// ----------------------------------------------------------------------------
// facrr_pkg
// Shared types and constants for the fully associative random-replace cache:
// transfer item structs, field widths, generator constants and mode codes.
// ----------------------------------------------------------------------------
package facrr_pkg;

	// field widths
	localparam int ADDR_W   = 32;
	localparam int TAG_W    = 28;
	localparam int VICTIM_W = 12;
	localparam int LOG2_W   = 3;
	localparam int RNG_W    = 32;

	// default geometry
	localparam int CAPACITY_BYTES_DEF = 64 * 1024;
	localparam int MAX_SLOTS_DEF      = 4096;

	// line size exponent: reset value and floor
	localparam logic [LOG2_W-1:0] LOG2_RESET = 3'd4;
	localparam logic [LOG2_W-1:0] LOG2_MIN   = 3'd4;

	// multiply-with-carry generator
	localparam logic [RNG_W-1:0] RNG_HIGH_RESET = 32'h0508_0902;
	localparam logic [RNG_W-1:0] RNG_LOW_RESET  = 32'hABAB_AB55;
	localparam logic [RNG_W-1:0] RNG_HIGH_MULT  = 32'd36969;
	localparam logic [RNG_W-1:0] RNG_LOW_MULT   = 32'd18000;

	// item modes
	localparam logic MODE_LOOKUP     = 1'b0;
	localparam logic MODE_INVALIDATE = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] address;
	} req_item_t;

	typedef struct packed {
		logic                hit;
		logic [VICTIM_W-1:0] victim_slot;
	} rsp_item_t;

endpackage

@@ rtl/core/facrr_tag_ram.sv @@
// ----------------------------------------------------------------------------
// facrr_tag_ram
// Slot store: one valid bit and one tag per slot, one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module facrr_tag_ram #(
	parameter int DEPTH = facrr_pkg::MAX_SLOTS_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [IDX_W-1:0]           waddr,
	input  logic [facrr_pkg::TAG_W:0]  wdata,
	input  logic [IDX_W-1:0]           raddr,
	output logic [facrr_pkg::TAG_W:0]  rdata
);

	logic [facrr_pkg::TAG_W:0] mem [DEPTH];
	logic [facrr_pkg::TAG_W:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/facrr_rng.sv @@
// ----------------------------------------------------------------------------
// facrr_rng
// Multiply-with-carry generator built from two 32-bit halves; stepped once
// per miss, output is the high half shifted up plus the low half.
// ----------------------------------------------------------------------------
module facrr_rng (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	output logic [facrr_pkg::RNG_W-1:0] value
);

	logic [facrr_pkg::RNG_W-1:0] high_q;
	logic [facrr_pkg::RNG_W-1:0] low_q;
	logic [facrr_pkg::RNG_W-1:0] high_d;
	logic [facrr_pkg::RNG_W-1:0] low_d;

	// next state of both halves
	always_comb begin
		high_d = ({16'h0, high_q[15:0]} * facrr_pkg::RNG_HIGH_MULT) + {16'h0, high_q[31:16]};
		low_d  = ({16'h0, low_q[15:0]} * facrr_pkg::RNG_LOW_MULT) + {16'h0, low_q[31:16]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= facrr_pkg::RNG_HIGH_RESET;
			low_q  <= facrr_pkg::RNG_LOW_RESET;
		end else if (step) begin
			high_q <= high_d;
			low_q  <= low_d;
		end
	end

	// combined output
	assign value = {high_q[15:0], 16'h0} + low_q;

endmodule

@@ rtl/core/facrr_mod.sv @@
// ----------------------------------------------------------------------------
// facrr_mod
// Iterative restoring remainder unit: one dividend bit per cycle; done pulses
// one cycle with the remainder valid.
// ----------------------------------------------------------------------------
module facrr_mod #(
	parameter int CNT_W = 13
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [facrr_pkg::RNG_W-1:0] dividend,
	input  logic [CNT_W-1:0]            divisor,
	output logic                        done,
	output logic [CNT_W-1:0]            remainder
);

	localparam int STEPS  = facrr_pkg::RNG_W;
	localparam int STEP_W = $clog2(STEPS);

	logic                        busy_q;
	logic                        done_q;
	logic [STEP_W-1:0]           step_q;
	logic [facrr_pkg::RNG_W-1:0] dvd_q;
	logic [CNT_W-1:0]            div_q;
	logic [CNT_W-1:0]            rem_q;
	logic [CNT_W:0]              trial;
	logic [CNT_W:0]              diff;
	logic [CNT_W-1:0]            rem_d;

	// shift in the next dividend bit and subtract when it fits
	always_comb begin
		trial = {rem_q, dvd_q[facrr_pkg::RNG_W-1]};
		diff  = trial - {1'b0, div_q};
		rem_d = (trial >= {1'b0, div_q}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			dvd_q  <= '0;
			div_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
			dvd_q  <= dividend;
			div_q  <= divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_d;
			dvd_q  <= {dvd_q[facrr_pkg::RNG_W-2:0], 1'b0};
			step_q <= step_q + STEP_W'(1);
			done_q <= (step_q == STEP_W'(STEPS - 1));
			if (step_q == STEP_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ rtl/core/fully_assoc_cache_random_replace.sv @@
// ----------------------------------------------------------------------------
// fully_assoc_cache_random_replace
// Tag-only fully associative cache with random replacement.
// ----------------------------------------------------------------------------
// One item at a time. A lookup reads the slot store one entry per cycle over
// the active slots (CAPACITY_BYTES >> line size exponent, at most MAX_SLOTS);
// a hit ends the scan early, and a miss runs the whole scan, one generator
// step and the remainder unit that picks the victim. An invalidate item sweeps
// the whole store, one entry per cycle. After reset the same sweep clears the
// store and req_stall stays high meanwhile; configuration writes are taken at
// any time and must only come while idle.
// ----------------------------------------------------------------------------
module fully_assoc_cache_random_replace #(
	parameter int CAPACITY_BYTES = facrr_pkg::CAPACITY_BYTES_DEF,
	parameter int MAX_SLOTS      = facrr_pkg::MAX_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  facrr_pkg::req_item_t             req_item,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output facrr_pkg::rsp_item_t             rsp_item,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [facrr_pkg::LOG2_W-1:0]     cfg_data
);

	localparam int IDX_W = $clog2(MAX_SLOTS);
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int CAP_W = $clog2(CAPACITY_BYTES + 1);
	localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;
	localparam int TAG_W = facrr_pkg::TAG_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_RNG,
		ST_MOD,
		ST_RESP
	} state_t;

	state_t                           state_q;
	logic [facrr_pkg::LOG2_W-1:0]     log2_q;
	logic [IDX_W-1:0]                 clr_idx_q;
	logic                             inv_q;
	logic [TAG_W-1:0]                 tag_q;
	logic [CNT_W-1:0]                 n_q;
	logic [CNT_W-1:0]                 issue_q;
	logic                             chk_s1;
	logic                             last_s1;
	logic                             res_hit_q;
	logic [facrr_pkg::VICTIM_W-1:0]   res_victim_q;
	logic                             rsp_valid_q;
	facrr_pkg::rsp_item_t             rsp_q;

	logic [facrr_pkg::LOG2_W-1:0]     eff_log2;
	logic [facrr_pkg::ADDR_W-1:0]     addr_shift;
	logic [CMP_W-1:0]                 cap_shift;
	logic [CNT_W-1:0]                 n_calc;
	logic                             issue;
	logic                             hit_now;
	logic                             ram_we;
	logic [IDX_W-1:0]                 ram_waddr;
	logic [TAG_W:0]                   ram_wdata;
	logic [IDX_W-1:0]                 ram_raddr;
	logic [TAG_W:0]                   ram_rdata;
	logic                             rng_step;
	logic [facrr_pkg::RNG_W-1:0]      rng_value;
	logic                             mod_start;
	logic                             mod_done;
	logic [CNT_W-1:0]                 mod_rem;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q <= facrr_pkg::LOG2_RESET;
		end else if (cfg_valid && cfg_ready) begin
			log2_q <= cfg_data;
		end
	end

	// tag and active slot count for the incoming item
	always_comb begin
		eff_log2   = (log2_q < facrr_pkg::LOG2_MIN) ? facrr_pkg::LOG2_MIN : log2_q;
		addr_shift = req_item.address >> eff_log2;
		cap_shift  = CMP_W'(CAPACITY_BYTES) >> eff_log2;
		if (cap_shift > CMP_W'(MAX_SLOTS)) begin
			n_calc = CNT_W'(MAX_SLOTS);
		end else if (cap_shift == '0) begin
			n_calc = CNT_W'(1);
		end else begin
			n_calc = cap_shift[CNT_W-1:0];
		end
	end

	// scan issue and compare
	assign issue   = (state_q == ST_SCAN) && (issue_q < n_q);
	assign hit_now = chk_s1 && ram_rdata[TAG_W] && (ram_rdata[TAG_W-1:0] == tag_q);

	// slot store port control
	always_comb begin
		ram_raddr = issue_q[IDX_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = clr_idx_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if ((state_q == ST_MOD) && mod_done) begin
			ram_we    = 1'b1;
			ram_waddr = mod_rem[IDX_W-1:0];
			ram_wdata = {1'b1, tag_q};
		end
	end

	assign rng_step  = (state_q == ST_SCAN) && chk_s1 && !hit_now && last_s1;
	assign mod_start = (state_q == ST_RNG);

	facrr_tag_ram #(
		.DEPTH (MAX_SLOTS),
		.IDX_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	facrr_rng u_rng (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (rng_step),
		.value  (rng_value)
	);

	facrr_mod #(
		.CNT_W (CNT_W)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (rng_value),
		.divisor   (n_q),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_idx_q    <= '0;
			inv_q        <= 1'b0;
			tag_q        <= '0;
			n_q          <= CNT_W'(1);
			issue_q      <= '0;
			chk_s1       <= 1'b0;
			last_s1      <= 1'b0;
			res_hit_q    <= 1'b0;
			res_victim_q <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			// output transfer drains the result register
			if (rsp_valid_q && !rsp_stall && (state_q != ST_RESP)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_idx_q == IDX_W'(MAX_SLOTS - 1)) begin
						clr_idx_q <= '0;
						if (inv_q) begin
							inv_q        <= 1'b0;
							res_hit_q    <= 1'b0;
							res_victim_q <= '0;
							state_q      <= ST_RESP;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						clr_idx_q <= clr_idx_q + IDX_W'(1);
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						if (req_item.mode == facrr_pkg::MODE_INVALIDATE) begin
							inv_q     <= 1'b1;
							clr_idx_q <= '0;
							state_q   <= ST_CLEAR;
						end else begin
							tag_q   <= addr_shift[TAG_W-1:0];
							n_q     <= n_calc;
							issue_q <= '0;
							chk_s1  <= 1'b0;
							last_s1 <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					chk_s1  <= issue;
					last_s1 <= (issue_q == (n_q - CNT_W'(1)));
					if (issue) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (hit_now) begin
						res_hit_q    <= 1'b1;
						res_victim_q <= '0;
						state_q      <= ST_RESP;
					end else if (chk_s1 && last_s1) begin
						state_q <= ST_RNG;
					end
				end
				ST_RNG: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (mod_done) begin
						res_hit_q    <= 1'b0;
						res_victim_q <= facrr_pkg::VICTIM_W'(mod_rem[IDX_W-1:0]);
						state_q      <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.hit         <= res_hit_q;
						rsp_q.victim_slot <= res_victim_q;
						rsp_valid_q       <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

endmodule

@@ rtl/core/facrr_checker.sv @@
// ----------------------------------------------------------------------------
// facrr_checker
// Port-level checks for the fully associative random-replace cache, bound
// to the top level.
// ----------------------------------------------------------------------------
module facrr_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  facrr_pkg::rsp_item_t rsp_item,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall
);

	// a stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result dropped while stalled");

	// a hit never names a victim slot
	a_hit_no_victim: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.hit |-> rsp_item.victim_slot == '0)
		else $error("hit result carries a victim slot");

	// the block is busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("input not stalled after a transfer");

	// a new result only appears while an item is in work
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared with no item in work");

endmodule

bind fully_assoc_cache_random_replace facrr_checker u_facrr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_item  (rsp_item),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall)
);

@@ verif/tb_fully_assoc_cache_random_replace.sv @@
// ----------------------------------------------------------------------------
// tb_fully_assoc_cache_random_replace
// Self-checking bench for the tag-only random-replace cache. A directed
// script covers the address and line-size extremes, invalidates and repeat
// hits. Random lookups follow, mostly reusing earlier lines. Every transfer
// is checked against a shadow copy of the slot store and the generator.
// ----------------------------------------------------------------------------
module tb_fully_assoc_cache_random_replace;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic {ROW_ITEM, ROW_LINE_SIZE} row_kind_t;

	typedef struct {
		row_kind_t                    kind;
		facrr_pkg::req_item_t         item;
		logic [facrr_pkg::LOG2_W-1:0] line_log2;
		bit                           typed;
		facrr_pkg::rsp_item_t         want;
	} script_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         req_valid = 1'b0;
	logic                         req_stall;
	facrr_pkg::req_item_t         req_item = '0;
	logic                         rsp_valid;
	logic                         rsp_stall = 1'b0;
	facrr_pkg::rsp_item_t         rsp_item;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [facrr_pkg::LOG2_W-1:0] cfg_data = '0;

	// shadow of the cache state
	bit                           shadow_valid [facrr_pkg::MAX_SLOTS_DEF];
	bit [facrr_pkg::TAG_W-1:0]    shadow_tag [facrr_pkg::MAX_SLOTS_DEF];
	logic [facrr_pkg::RNG_W-1:0]  mwc_hi = facrr_pkg::RNG_HIGH_RESET;
	logic [facrr_pkg::RNG_W-1:0]  mwc_lo = facrr_pkg::RNG_LOW_RESET;
	logic [facrr_pkg::LOG2_W-1:0] shadow_log2 = facrr_pkg::LOG2_RESET;

	facrr_pkg::rsp_item_t pending_outcomes [$];
	logic [31:0]          seen_addrs [$];
	script_row_t          script [$];
	int                   fail_count = 0;
	bit                   quiet_req = 1'b0;
	bit                   quiet_rsp = 1'b0;

	fully_assoc_cache_random_replace uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop well past the slowest correct run
	initial begin
		#30_000_000;
		$display("tb_fully_assoc_cache_random_replace: done, errors");
		$finish;
	end

	// shift in force for the current line size
	function automatic int unsigned line_shift();
		return (shadow_log2 < facrr_pkg::LOG2_MIN) ? facrr_pkg::LOG2_MIN : shadow_log2;
	endfunction

	// outcome of one item, advancing the shadow state
	function automatic facrr_pkg::rsp_item_t cache_outcome(facrr_pkg::req_item_t it);
		facrr_pkg::rsp_item_t        r;
		int unsigned                 e;
		int unsigned                 n;
		int unsigned                 i;
		logic [facrr_pkg::TAG_W-1:0] t;
		logic [facrr_pkg::RNG_W-1:0] rnd;
		r = '0;
		if (it.mode == facrr_pkg::MODE_INVALIDATE) begin
			for (i = 0; i < facrr_pkg::MAX_SLOTS_DEF; i++) begin
				shadow_valid[i] = 1'b0;
				shadow_tag[i] = '0;
			end
			return r;
		end
		e = line_shift();
		n = facrr_pkg::CAPACITY_BYTES_DEF >> e;
		if (n > facrr_pkg::MAX_SLOTS_DEF)
			n = facrr_pkg::MAX_SLOTS_DEF;
		if (n == 0)
			n = 1;
		t = facrr_pkg::TAG_W'(it.address >> e);
		for (i = 0; i < n; i++) begin
			if (shadow_valid[i] && shadow_tag[i] == t) begin
				r.hit = 1'b1;
				return r;
			end
		end
		// multiply-with-carry step picks the victim
		mwc_hi = facrr_pkg::RNG_HIGH_MULT * (mwc_hi & 32'h0000_FFFF) + (mwc_hi >> 16);
		mwc_lo = facrr_pkg::RNG_LOW_MULT * (mwc_lo & 32'h0000_FFFF) + (mwc_lo >> 16);
		rnd = (mwc_hi << 16) + mwc_lo;
		r.victim_slot = facrr_pkg::VICTIM_W'(rnd % n);
		shadow_valid[rnd % n] = 1'b1;
		shadow_tag[rnd % n] = t;
		return r;
	endfunction

	function automatic script_row_t lookup_row(logic [31:0] a, bit known_hit);
		script_row_t row;
		row.kind = ROW_ITEM;
		row.item.mode = facrr_pkg::MODE_LOOKUP;
		row.item.address = a;
		row.line_log2 = '0;
		row.typed = known_hit;
		row.want.hit = 1'b1;
		row.want.victim_slot = '0;
		return row;
	endfunction

	function automatic script_row_t invalidate_row(logic [31:0] a);
		script_row_t row;
		row.kind = ROW_ITEM;
		row.item.mode = facrr_pkg::MODE_INVALIDATE;
		row.item.address = a;
		row.line_log2 = '0;
		row.typed = 1'b1;
		row.want = '0;
		return row;
	endfunction

	function automatic script_row_t line_size_row(logic [facrr_pkg::LOG2_W-1:0] v);
		script_row_t row;
		row.kind = ROW_LINE_SIZE;
		row.item = '0;
		row.line_log2 = v;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	// one request transfer; called at a falling edge, returns at one
	task automatic send_item(facrr_pkg::req_item_t it, bit typed, facrr_pkg::rsp_item_t want);
		int unsigned          gap;
		facrr_pkg::rsp_item_t predicted;
		gap = quiet_req ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_item <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predicted = cache_outcome(it);
		pending_outcomes.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// line size write once every outstanding result is back
	task automatic write_line_size(logic [facrr_pkg::LOG2_W-1:0] v);
		req_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		shadow_log2 = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result sink and checker
	initial begin
		int unsigned          hold;
		facrr_pkg::rsp_item_t want;
		forever begin
			hold = quiet_rsp ? 0 : $urandom_range(0, 13);
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
			if (pending_outcomes.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: hit=%0b victim=%0d",
						rsp_item.hit, rsp_item.victim_slot);
			end else begin
				want = pending_outcomes.pop_front();
				if (rsp_item.hit !== want.hit
						|| rsp_item.victim_slot !== want.victim_slot) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: expected hit=%0b victim=%0d, got hit=%0b victim=%0d",
							want.hit, want.victim_slot, rsp_item.hit, rsp_item.victim_slot);
				end
			end
			@(negedge clk);
		end
	end

	// stimulus
	initial begin
		logic [facrr_pkg::LOG2_W-1:0] phase_log2 [7];
		facrr_pkg::req_item_t         it;
		int unsigned                  pick;
		logic [31:0]                  low_bits;
		logic [31:0]                  base;

		phase_log2 = '{3'd7, 3'd4, 3'd6, 3'd0, 3'd5, 3'd3, 3'd7};

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		script = '{
			lookup_row(32'h0000_0000, 1'b0),
			lookup_row(32'h0000_0000, 1'b1),
			lookup_row(32'h0000_000F, 1'b1),
			lookup_row(32'hFFFF_FFFF, 1'b0),
			lookup_row(32'hFFFF_FFF0, 1'b1),
			lookup_row(32'h0000_0010, 1'b0),
			invalidate_row(32'hFFFF_FFFF),
			lookup_row(32'h0000_0000, 1'b0),
			lookup_row(32'hAAAA_AAAA, 1'b0),
			lookup_row(32'h5555_5555, 1'b0),
			line_size_row(3'd7),
			lookup_row(32'h0000_0000, 1'b0),
			lookup_row(32'hFFFF_FFFF, 1'b0),
			lookup_row(32'hFFFF_FF80, 1'b1),
			line_size_row(3'd0),
			lookup_row(32'hFFFF_FFF0, 1'b0),
			line_size_row(3'd3),
			lookup_row(32'h1234_5678, 1'b0),
			lookup_row(32'h1234_567F, 1'b1),
			line_size_row(3'd5),
			lookup_row(32'h8000_0000, 1'b0),
			line_size_row(3'd6),
			lookup_row(32'h7FFF_FFFF, 1'b0),
			line_size_row(3'd1),
			lookup_row(32'hFFFF_FFF0, 1'b0),
			line_size_row(3'd2),
			lookup_row(32'h0000_0000, 1'b0),
			invalidate_row(32'h0000_0000),
			line_size_row(3'd4)
		};

		// directed script
		foreach (script[k]) begin
			if (script[k].kind == ROW_LINE_SIZE)
				write_line_size(script[k].line_log2);
			else
				send_item(script[k].item, script[k].typed, script[k].want);
		end

		// random phases, each under its own line size
		foreach (phase_log2[p]) begin
			write_line_size(phase_log2[p]);
			quiet_req = ($urandom_range(0, 3) == 0);
			quiet_rsp = ($urandom_range(0, 3) == 0);
			low_bits = (32'd1 << line_shift()) - 1;
			repeat (17) begin
				pick = $urandom_range(0, 99);
				it.mode = facrr_pkg::MODE_LOOKUP;
				it.address = $urandom;
				if (pick < 7) begin
					it.mode = facrr_pkg::MODE_INVALIDATE;
				end else if (pick < 60 && seen_addrs.size() != 0) begin
					// same line as an earlier address, other byte offset
					base = seen_addrs[$urandom_range(0, seen_addrs.size() - 1)];
					it.address = (base & ~low_bits) | (it.address & low_bits);
				end else begin
					// fresh line, sometimes right next to an earlier one
					if (pick < 72 && seen_addrs.size() != 0)
						it.address = seen_addrs[$urandom_range(0, seen_addrs.size() - 1)]
							+ low_bits + 1;
					seen_addrs.push_back(it.address);
					if (seen_addrs.size() > 24)
						void'(seen_addrs.pop_front());
				end
				send_item(it, 1'b0, '0);
			end
		end

		// drain, then a short tail for stray results
		req_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("tb_fully_assoc_cache_random_replace: done, clean");
		else
			$display("tb_fully_assoc_cache_random_replace: done, errors");
		$finish;
	end

endmodule
